/* sv/gcd_pkg.sv */
// ----------------------------------------------------------------------------
// gcd_pkg: shared constants for the great-circle distance pipeline
// Fixed-point formats, CORDIC tables and angle reduction helpers.
// ----------------------------------------------------------------------------
package gcd_pkg;

    localparam int ANGLE_FRAC_BITS = 22;
    localparam int TRIG_STEPS      = 32;
    localparam int WF              = 30;

    localparam int RA_W  = 31;
    localparam int DEC_W = 30;
    localparam int SEP_W = 32;
    localparam int S_TDATA_W = ((2 * RA_W + 2 * DEC_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((SEP_W + 7) / 8) * 8;

    localparam logic [63:0] FULL_DEG    = 64'd360 << ANGLE_FRAC_BITS;
    localparam logic [63:0] HALF_DEG    = FULL_DEG >> 1;
    localparam logic [63:0] QUARTER_DEG = FULL_DEG >> 2;

    localparam int RED_W = $clog2(FULL_DEG) + 3;
    localparam int M_W   = $clog2(QUARTER_DEG) + 2;

    localparam logic signed [RED_W-1:0] FULL_S     = RED_W'(FULL_DEG);
    localparam logic signed [RED_W-1:0] TWO_FULL_S = RED_W'(FULL_DEG << 1);
    localparam logic signed [RED_W-1:0] HALF_S     = RED_W'(HALF_DEG);
    localparam logic signed [RED_W-1:0] QUARTER_S  = RED_W'(QUARTER_DEG);

    localparam int CW     = WF + 3;
    localparam int MUL_W  = 2 * CW;
    localparam int SQ_W   = 2 * WF + 1;
    localparam int RT_W   = WF + 1;
    localparam int LAT    = 3 + TRIG_STEPS + 5 + (WF + 1) + 1 + TRIG_STEPS + 1;

    typedef logic signed [CW-1:0] atan_arr_t [TRIG_STEPS];

    typedef struct packed {
        logic signed [M_W-1:0] m;
        logic                  neg;
    } red_t;

    function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], n[i]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        n = v;
        r = '0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] atan_recip(input logic [63:0] n);
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] nn;
        logic [63:0] term;
        p   = udiv(64'd1 << 60, n);
        nn  = n * n;
        sum = '0;
        for (int k = 0; k < 64; k++) begin
            if (p != 0) begin
                term = udiv(p, 64'(2 * k + 1));
                if (k % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
                p = udiv(p, nn);
            end
        end
        return sum;
    endfunction

    localparam logic [63:0] PI4 = 64'd4 * atan_recip(64'd5) - atan_recip(64'd239);
    localparam logic [63:0] RHALF = 64'd1 << (60 - WF - 1);

    function automatic atan_arr_t atan_build();
        atan_arr_t   t;
        logic [63:0] sum;
        logic [63:0] term;
        for (int i = 0; i < TRIG_STEPS; i++) begin
            if (i == 0) begin
                sum = PI4;
            end else begin
                sum = '0;
                for (int k = 0; k < 31; k++) begin
                    if (i * (2 * k + 1) <= 60) begin
                        term = udiv(64'd1 << (60 - i * (2 * k + 1)), 64'(2 * k + 1));
                        if (k % 2 == 1) begin
                            sum = sum - term;
                        end else begin
                            sum = sum + term;
                        end
                    end
                end
            end
            t[i] = CW'((sum + RHALF) >> (60 - WF));
        end
        return t;
    endfunction

    function automatic logic [63:0] gain_build();
        logic [63:0] prod;
        logic [63:0] root;
        prod = 64'd1 << 60;
        for (int i = 0; i < TRIG_STEPS; i++) begin
            if (2 * i < 64) begin
                prod = prod + (prod >> (2 * i));
            end
        end
        root = isqrt64(prod);
        return udiv((64'd1 << 60) + (root >> 1), root);
    endfunction

    function automatic logic [63:0] d2r_build();
        logic [63:0] r;
        logic [63:0] q;
        r = 64'd174532925199433;
        q = '0;
        for (int b = 0; b < 60 - ANGLE_FRAC_BITS; b++) begin
            r = r << 1;
            q = q << 1;
            if (r >= 64'd10000000000000000) begin
                r    = r - 64'd10000000000000000;
                q[0] = 1'b1;
            end
        end
        if ((r << 1) >= 64'd10000000000000000) begin
            q = q + 64'd1;
        end
        return q;
    endfunction

    localparam atan_arr_t ATAN_TAB = atan_build();

    localparam logic [63:0] D2R_FIX = d2r_build();
    localparam int D2R_W = $clog2(D2R_FIX) + 1;
    localparam int P_W   = M_W + D2R_W + 1;
    localparam logic signed [P_W-1:0] D2R_S = P_W'(D2R_FIX);

    localparam logic signed [CW-1:0] GAIN_Q    = CW'(gain_build());
    localparam logic signed [CW-1:0] PI_Q      = CW'(((PI4 << 2) + RHALF) >> (60 - WF));
    localparam logic signed [CW-1:0] HALF_PI_Q = CW'(((PI4 << 1) + RHALF) >> (60 - WF));
    localparam logic signed [CW:0]   ONE_Q     = (CW + 1)'(1) <<< WF;

    function automatic red_t reduce(input logic signed [RED_W-1:0] d);
        logic signed [RED_W-1:0] r;
        red_t                    o;
        if (d >= FULL_S) begin
            r = d - FULL_S;
        end else if (d >= 0) begin
            r = d;
        end else if (d + FULL_S >= 0) begin
            r = d + FULL_S;
        end else begin
            r = d + TWO_FULL_S;
        end
        if (r > HALF_S) begin
            r = r - FULL_S;
        end
        o.neg = 1'b0;
        if (r > QUARTER_S) begin
            r     = HALF_S - r;
            o.neg = 1'b1;
        end else if (r < -QUARTER_S) begin
            r     = -HALF_S - r;
            o.neg = 1'b1;
        end
        o.m = M_W'(r);
        return o;
    endfunction

    function automatic logic signed [CW-1:0] rnd_ang(input logic signed [P_W-1:0] p);
        logic signed [P_W-1:0] h;
        h         = '0;
        h[WF-1]   = 1'b1;
        return CW'((p + h) >>> WF);
    endfunction

    function automatic logic signed [CW-1:0] rnd_mul(input logic signed [MUL_W-1:0] p);
        logic signed [MUL_W-1:0] h;
        h         = '0;
        h[WF-1]   = 1'b1;
        return CW'((p + h) >>> WF);
    endfunction

endpackage

/* sv/great_circle_distance.sv */
// ----------------------------------------------------------------------------
// great_circle_distance: angular separation of two sky positions
// Throughput: one transaction per cycle while m_tready is high.
// The whole pipeline holds when the output register is full and not taken.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module great_circle_distance
    import gcd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // ra_a[30:0], dec_a[60:31], ra_b[91:61], dec_b[121:92], zero pad
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // separation[31:0]
    output logic [M_TDATA_W-1:0]  m_tdata
);

    logic                    adv;
    logic [LAT-1:0]          vld_reg;

    logic [RA_W-1:0]         ra_a;
    logic [RA_W-1:0]         ra_b;
    logic signed [DEC_W-1:0] dec_a;
    logic signed [DEC_W-1:0] dec_b;
    logic signed [RED_W-1:0] ra_diff;
    red_t                    red_next [3];

    logic signed [M_W-1:0]   m_reg    [3];
    logic                    neg1_reg [3];
    logic signed [P_W-1:0]   prod_reg [3];
    logic                    neg2_reg [3];

    logic signed [CW-1:0]    rx_reg  [TRIG_STEPS+1][3];
    logic signed [CW-1:0]    ry_reg  [TRIG_STEPS+1][3];
    logic signed [CW-1:0]    rz_reg  [TRIG_STEPS+1][3];
    logic                    rn_reg  [TRIG_STEPS+1][3];

    logic signed [CW-1:0]    cos_next [3];
    logic signed [MUL_W-1:0] pcc_reg;
    logic signed [MUL_W-1:0] pss_reg;
    logic signed [CW-1:0]    cr1_reg;
    logic signed [CW-1:0]    t_reg;
    logic signed [CW-1:0]    s2_reg;
    logic signed [CW-1:0]    cr2_reg;
    logic signed [MUL_W-1:0] p3_reg;
    logic signed [CW-1:0]    s3_reg;
    logic signed [CW:0]      csum_next;
    logic signed [CW-1:0]    c_reg;
    logic signed [CW:0]      om_next;
    logic signed [CW:0]      op_next;

    logic [SQ_W-1:0]         sq_n_reg [WF+2];
    logic [SQ_W-1:0]         sq_r_reg [WF+2];
    logic signed [CW-1:0]    sq_c_reg [WF+2];

    logic signed [CW-1:0]    vx_reg [TRIG_STEPS+1];
    logic signed [CW-1:0]    vy_reg [TRIG_STEPS+1];
    logic signed [CW-1:0]    vz_reg [TRIG_STEPS+1];
    logic signed [CW-1:0]    root_next;

    logic [SEP_W-1:0]        sep_reg;

    assign adv      = m_tready || !vld_reg[LAT-1];
    assign s_tready = adv;
    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = M_TDATA_W'(sep_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    assign ra_a  = s_tdata[RA_W-1:0];
    assign dec_a = s_tdata[RA_W+DEC_W-1:RA_W];
    assign ra_b  = s_tdata[2*RA_W+DEC_W-1:RA_W+DEC_W];
    assign dec_b = s_tdata[2*RA_W+2*DEC_W-1:2*RA_W+DEC_W];

    assign ra_diff = $signed({{(RED_W-RA_W){1'b0}}, ra_a})
                   - $signed({{(RED_W-RA_W){1'b0}}, ra_b});

    always_comb begin
        red_next[0] = reduce(RED_W'(dec_a));
        red_next[1] = reduce(RED_W'(dec_b));
        red_next[2] = reduce(ra_diff);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < 3; j++) begin
                m_reg[j]       <= red_next[j].m;
                neg1_reg[j]    <= red_next[j].neg;
                prod_reg[j]    <= P_W'(m_reg[j]) * D2R_S;
                neg2_reg[j]    <= neg1_reg[j];
                rx_reg[0][j]   <= GAIN_Q;
                ry_reg[0][j]   <= '0;
                rz_reg[0][j]   <= rnd_ang(prod_reg[j]);
                rn_reg[0][j]   <= neg2_reg[j];
            end
        end
    end

    for (genvar k = 0; k < TRIG_STEPS; k++) begin : g_rot
        always_ff @(posedge aclk) begin
            if (adv) begin
                for (int j = 0; j < 3; j++) begin
                    if (rz_reg[k][j] >= 0) begin
                        rx_reg[k+1][j] <= rx_reg[k][j] - (ry_reg[k][j] >>> k);
                        ry_reg[k+1][j] <= ry_reg[k][j] + (rx_reg[k][j] >>> k);
                        rz_reg[k+1][j] <= rz_reg[k][j] - ATAN_TAB[k];
                    end else begin
                        rx_reg[k+1][j] <= rx_reg[k][j] + (ry_reg[k][j] >>> k);
                        ry_reg[k+1][j] <= ry_reg[k][j] - (rx_reg[k][j] >>> k);
                        rz_reg[k+1][j] <= rz_reg[k][j] + ATAN_TAB[k];
                    end
                    rn_reg[k+1][j] <= rn_reg[k][j];
                end
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            cos_next[j] = rn_reg[TRIG_STEPS][j] ? -rx_reg[TRIG_STEPS][j]
                                                : rx_reg[TRIG_STEPS][j];
        end
    end

    assign csum_next = (CW + 1)'(s3_reg) + (CW + 1)'(rnd_mul(p3_reg));
    assign om_next   = ONE_Q - (CW + 1)'(c_reg);
    assign op_next   = ONE_Q + (CW + 1)'(c_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            pcc_reg <= MUL_W'(cos_next[0]) * MUL_W'(cos_next[1]);
            pss_reg <= MUL_W'(ry_reg[TRIG_STEPS][0]) * MUL_W'(ry_reg[TRIG_STEPS][1]);
            cr1_reg <= cos_next[2];
            t_reg   <= rnd_mul(pcc_reg);
            s2_reg  <= rnd_mul(pss_reg);
            cr2_reg <= cr1_reg;
            p3_reg  <= MUL_W'(t_reg) * MUL_W'(cr2_reg);
            s3_reg  <= s2_reg;
            if (csum_next < -ONE_Q) begin
                c_reg <= CW'(-ONE_Q);
            end else if (csum_next > ONE_Q) begin
                c_reg <= CW'(ONE_Q);
            end else begin
                c_reg <= CW'(csum_next);
            end
            sq_n_reg[0] <= SQ_W'(SQ_W'(om_next) * SQ_W'(op_next));
            sq_r_reg[0] <= '0;
            sq_c_reg[0] <= c_reg;
        end
    end

    for (genvar s = 0; s <= WF; s++) begin : g_sqrt
        localparam logic [SQ_W-1:0] SQ_BIT = SQ_W'(1) << (2 * (WF - s));
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (sq_n_reg[s] >= sq_r_reg[s] + SQ_BIT) begin
                    sq_n_reg[s+1] <= sq_n_reg[s] - (sq_r_reg[s] + SQ_BIT);
                    sq_r_reg[s+1] <= (sq_r_reg[s] >> 1) + SQ_BIT;
                end else begin
                    sq_n_reg[s+1] <= sq_n_reg[s];
                    sq_r_reg[s+1] <= sq_r_reg[s] >> 1;
                end
                sq_c_reg[s+1] <= sq_c_reg[s];
            end
        end
    end

    assign root_next = CW'(sq_r_reg[WF+1][RT_W-1:0]);

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (sq_c_reg[WF+1] < 0) begin
                vx_reg[0] <= root_next;
                vy_reg[0] <= -sq_c_reg[WF+1];
                vz_reg[0] <= HALF_PI_Q;
            end else begin
                vx_reg[0] <= sq_c_reg[WF+1];
                vy_reg[0] <= root_next;
                vz_reg[0] <= '0;
            end
        end
    end

    for (genvar k = 0; k < TRIG_STEPS; k++) begin : g_vec
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (vy_reg[k] >= 0) begin
                    vx_reg[k+1] <= vx_reg[k] + (vy_reg[k] >>> k);
                    vy_reg[k+1] <= vy_reg[k] - (vx_reg[k] >>> k);
                    vz_reg[k+1] <= vz_reg[k] + ATAN_TAB[k];
                end else begin
                    vx_reg[k+1] <= vx_reg[k] - (vy_reg[k] >>> k);
                    vy_reg[k+1] <= vy_reg[k] + (vx_reg[k] >>> k);
                    vz_reg[k+1] <= vz_reg[k] - ATAN_TAB[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (vz_reg[TRIG_STEPS] < 0) begin
                sep_reg <= '0;
            end else if (vz_reg[TRIG_STEPS] > PI_Q) begin
                sep_reg <= SEP_W'(PI_Q);
            end else begin
                sep_reg <= SEP_W'(vz_reg[TRIG_STEPS]);
            end
        end
    end

endmodule

/* sv/gcd_checker.sv */
// ----------------------------------------------------------------------------
// gcd_checker: port-level checks for great_circle_distance
// Watches the stream ports and flags output and stall misbehavior.
// ----------------------------------------------------------------------------
module gcd_checker
    import gcd_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [S_TDATA_W-1:0]  s_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata
);

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input transaction changed while stalled");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result transaction changed while stalled");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[SEP_W-1:0] <= SEP_W'(PI_Q))
        else $error("separation above pi");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

endmodule

bind great_circle_distance gcd_checker u_gcd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
